>>> src/ale_pkg.sv
package ale_pkg;

	// default scan limits
	localparam int COLUMN_LIMIT_DEF = 16;
	localparam int ARG_CHARS_DEF    = 7;

	// line records held between scanner and encoder
	localparam int QUEUE_DEPTH = 2;

	// mnemonic buffer
	localparam int MNEM_CHARS = 5;
	localparam int MNEM_LEN_W = 3;
	localparam int OP_COUNT   = 16;

	// opcodes with special encodings
	localparam logic [3:0] OP_NOP   = 4'd0;
	localparam logic [3:0] OP_JMP   = 4'd13;
	localparam logic [3:0] OP_FLG   = 4'd14;
	localparam logic [3:0] OP_RSTFG = 4'd15;

	// register codes
	localparam logic [1:0] REG_NONE = 2'd0;
	localparam logic [1:0] REG_AL   = 2'd1;
	localparam logic [1:0] REG_BL   = 2'd2;
	localparam logic [1:0] REG_CL   = 2'd3;

	localparam logic [15:0] TXT_AL = "AL";
	localparam logic [15:0] TXT_BL = "BL";
	localparam logic [15:0] TXT_CL = "CL";

	localparam logic [7:0] CH_SEMI  = ";";
	localparam logic [7:0] CH_COMMA = ",";

	// mnemonic names, first character in the top byte, padded with blanks
	localparam logic [8*MNEM_CHARS-1:0] OP_NAME [OP_COUNT] = '{
		"NOP  ", "MOV  ", "STOR ", "LOAD ", "INC  ", "ADD  ", "ADDIV", "DEC  ",
		"SUB  ", "SUBIV", "OR   ", "AND  ", "CMP  ", "JMP  ", "FLG  ", "RSTFG"
	};
	localparam logic [MNEM_LEN_W-1:0] OP_LEN [OP_COUNT] = '{
		3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd5, 3'd3,
		3'd3, 3'd5, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd5
	};

	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
	} char_item_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_of_line;
		logic       bad_line;
	} code_item_t;

	// one scanned line, ready for encoding
	typedef struct packed {
		logic [MNEM_CHARS-1:0][7:0] mnem;
		logic [MNEM_LEN_W-1:0]      mnem_len;
		logic                       fault;
		logic [1:0]                 reg0;
		logic [1:0]                 reg1;
		logic [7:0]                 num0;
		logic [7:0]                 num1;
	} line_rec_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] op;
	} op_find_t;

	// look up a mnemonic among the known names
	function automatic op_find_t find_op(input logic [MNEM_CHARS-1:0][7:0] mnem,
			input logic [MNEM_LEN_W-1:0] len);
		op_find_t r;
		logic     same;
		r.hit = 1'b0;
		r.op  = OP_NOP;
		for (int op = 0; op < OP_COUNT; op++) begin
			same = (len == OP_LEN[op]);
			for (int k = 0; k < MNEM_CHARS; k++) begin
				if ((MNEM_LEN_W'(k) < len) &&
						(mnem[k] != OP_NAME[op][8*(MNEM_CHARS-1-k) +: 8])) begin
					same = 1'b0;
				end
			end
			if (same && !r.hit) begin
				r.hit = 1'b1;
				r.op  = 4'(op);
			end
		end
		return r;
	endfunction

	// register code of an argument
	function automatic logic [1:0] reg_code(input logic is_two, input logic [15:0] head);
		logic [1:0] r;
		r = REG_NONE;
		if (is_two) begin
			if (head == TXT_AL) begin
				r = REG_AL;
			end else if (head == TXT_BL) begin
				r = REG_BL;
			end else if (head == TXT_CL) begin
				r = REG_CL;
			end
		end
		return r;
	endfunction

endpackage

>>> src/ale_front.sv
module ale_front import ale_pkg::*; #(
	parameter int COLUMN_LIMIT = COLUMN_LIMIT_DEF,
	parameter int ARG_CHARS    = ARG_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       chr_valid,
	output logic       chr_ready,
	input  char_item_t chr,
	input  logic       q_full,
	output logic       push,
	output line_rec_t  rec
);

	localparam int CW = $clog2(COLUMN_LIMIT + 1);
	localparam int AW = $clog2(ARG_CHARS + 1);

	logic [CW-1:0]         column_q, n_column;
	logic                  in_args_q, n_in_args;
	logic [7:0]            mnem_q [MNEM_CHARS];
	logic [7:0]            n_mnem [MNEM_CHARS];
	logic [MNEM_LEN_W-1:0] mlen_q, n_mlen;
	logic                  second_q, n_second;
	logic                  stopped_q, n_stopped;
	logic [AW-1:0]         alen_q [2];
	logic [AW-1:0]         n_alen [2];
	logic [15:0]           head_q [2];
	logic [15:0]           n_head [2];
	logic [7:0]            num_q [2];
	logic [7:0]            n_num [2];
	logic                  open_q [2];
	logic                  n_open [2];
	logic                  fault_q, n_fault;
	logic                  take;
	logic                  is_upper, is_digit;

	assign chr_ready = !q_full;
	assign take      = chr_valid && chr_ready;
	assign push      = take && chr.line_end;
	assign is_upper  = (chr.ch >= "A") && (chr.ch <= "Z");
	assign is_digit  = (chr.ch >= "0") && (chr.ch <= "9");

	// scan one character
	always_comb begin
		n_column  = column_q;
		n_in_args = in_args_q;
		n_mnem    = mnem_q;
		n_mlen    = mlen_q;
		n_second  = second_q;
		n_stopped = stopped_q;
		n_alen    = alen_q;
		n_head    = head_q;
		n_num     = num_q;
		n_open    = open_q;
		n_fault   = fault_q;
		if (column_q < CW'(COLUMN_LIMIT)) begin
			n_column = column_q + 1'b1;
			if (!in_args_q && is_upper) begin
				if (mlen_q < MNEM_LEN_W'(MNEM_CHARS)) begin
					n_mnem[mlen_q] = chr.ch;
				end
				if (mlen_q < MNEM_LEN_W'(MNEM_CHARS + 1)) begin
					n_mlen = mlen_q + 1'b1;
				end
			end else begin
				n_in_args = 1'b1;
				if (!stopped_q) begin
					if (chr.ch == CH_SEMI) begin
						n_stopped = 1'b1;
					end else if (chr.ch == CH_COMMA) begin
						// a further comma restarts the second argument
						if (second_q) begin
							n_alen[1] = '0;
							n_head[1] = '0;
							n_num[1]  = '0;
							n_open[1] = 1'b1;
						end
						n_second = 1'b1;
					end else if (is_upper || is_digit) begin
						if (alen_q[second_q] >= AW'(ARG_CHARS)) begin
							n_fault = 1'b1;
						end else begin
							if (alen_q[second_q] == AW'(0)) begin
								n_head[second_q][15:8] = chr.ch;
							end else if (alen_q[second_q] == AW'(1)) begin
								n_head[second_q][7:0] = chr.ch;
							end
							n_alen[second_q] = alen_q[second_q] + 1'b1;
							if (open_q[second_q] && is_digit) begin
								n_num[second_q] = (num_q[second_q] << 3) +
									(num_q[second_q] << 1) + {4'd0, chr.ch[3:0]};
							end else begin
								n_open[second_q] = 1'b0;
							end
						end
					end
				end
			end
		end
	end

	// line record from the scan including the last character
	always_comb begin
		for (int k = 0; k < MNEM_CHARS; k++) begin
			rec.mnem[k] = n_mnem[k];
		end
		rec.mnem_len = n_mlen;
		rec.fault    = n_fault;
		rec.reg0     = reg_code(n_alen[0] == AW'(2), n_head[0]);
		rec.reg1     = reg_code(n_alen[1] == AW'(2), n_head[1]);
		rec.num0     = n_num[0];
		rec.num1     = n_num[1];
	end

	// line control state, cleared after each line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			in_args_q <= 1'b0;
			mlen_q    <= '0;
			second_q  <= 1'b0;
			stopped_q <= 1'b0;
			fault_q   <= 1'b0;
			for (int a = 0; a < 2; a++) begin
				alen_q[a] <= '0;
				num_q[a]  <= '0;
				open_q[a] <= 1'b1;
			end
		end else if (take) begin
			if (chr.line_end) begin
				column_q  <= '0;
				in_args_q <= 1'b0;
				mlen_q    <= '0;
				second_q  <= 1'b0;
				stopped_q <= 1'b0;
				fault_q   <= 1'b0;
				for (int a = 0; a < 2; a++) begin
					alen_q[a] <= '0;
					num_q[a]  <= '0;
					open_q[a] <= 1'b1;
				end
			end else begin
				column_q  <= n_column;
				in_args_q <= n_in_args;
				mlen_q    <= n_mlen;
				second_q  <= n_second;
				stopped_q <= n_stopped;
				fault_q   <= n_fault;
				alen_q    <= n_alen;
				num_q     <= n_num;
				open_q    <= n_open;
			end
		end
	end

	// character buffers, only read where written this line
	always_ff @(posedge clk) begin
		if (take) begin
			mnem_q <= n_mnem;
			head_q <= n_head;
		end
	end

endmodule

>>> src/ale_queue.sv
module ale_queue import ale_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  line_rec_t push_rec,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output line_rec_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	line_rec_t     ent_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full       = (cnt_q == NW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// record storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> src/ale_back.sv
module ale_back import ale_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  line_rec_t  head,
	output logic       pop,
	output logic       code_valid,
	input  logic       code_ready,
	output code_item_t code
);

	op_find_t   found;
	code_item_t first, second;
	logic       two;
	logic [7:0] instr;
	logic       phase_q;
	logic       out_valid_q;
	code_item_t out_q;
	logic       load;

	// encode the line at the queue head
	always_comb begin
		found = find_op(head.mnem, head.mnem_len);
		instr = {found.op, head.reg0, head.reg1};
		first  = '{code_byte: 8'd0, last_of_line: 1'b1, bad_line: 1'b1};
		second = '{code_byte: head.num0, last_of_line: 1'b1, bad_line: 1'b0};
		two    = 1'b0;
		if (!found.hit) begin
			first = '{code_byte: 8'd0, last_of_line: 1'b1, bad_line: 1'b1};
		end else if (found.op == OP_NOP || found.op == OP_RSTFG) begin
			first = '{code_byte: {found.op, 4'd0}, last_of_line: 1'b1, bad_line: 1'b0};
		end else if (head.fault) begin
			first = '{code_byte: 8'd0, last_of_line: 1'b1, bad_line: 1'b1};
		end else if (found.op == OP_JMP || found.op == OP_FLG) begin
			first = '{code_byte: {found.op, 4'd0}, last_of_line: 1'b0, bad_line: 1'b0};
			two   = 1'b1;
		end else if (head.reg0 != REG_NONE && head.reg1 != REG_NONE) begin
			first = '{code_byte: instr, last_of_line: 1'b1, bad_line: 1'b0};
		end else begin
			first = '{code_byte: instr, last_of_line: 1'b0, bad_line: 1'b0};
			second.code_byte = (head.reg1 == REG_NONE) ? head.num1 : head.num0;
			two   = 1'b1;
		end
	end

	// next beat enters the output register when it is free or being taken
	assign load       = head_valid && (!out_valid_q || code_ready);
	assign pop        = load && (phase_q || !two);
	assign code_valid = out_valid_q;
	assign code       = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= phase_q ? second : first;
		end
	end

	// byte phase and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q     <= !phase_q && two;
				out_valid_q <= 1'b1;
			end else if (code_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/assembly_line_encoder.sv
// channel  | signals                       | beat
// ---------+-------------------------------+------------------------------------
// chr      | chr_valid, chr_ready, chr     | one source character, line_end flag
// code     | code_valid, code_ready, code  | one output byte with line flags
//
// one character is taken per cycle; the scanner does constant work per beat
// a line yields one or two code beats, one per ready cycle from the output register
// up to two scanned lines wait in the record queue; chr_ready drops while it is full
// a line is encoded once its record, pushed with its last character, heads the queue
// reset clears all control state; no clearing pass is needed
module assembly_line_encoder import ale_pkg::*; #(
	parameter int COLUMN_LIMIT = COLUMN_LIMIT_DEF,
	parameter int ARG_CHARS    = ARG_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       chr_valid,
	output logic       chr_ready,
	input  char_item_t chr,
	output logic       code_valid,
	input  logic       code_ready,
	output code_item_t code
);

	logic      q_full, q_push, q_pop, q_valid;
	line_rec_t q_in, q_head;

	// character scanner
	ale_front #(
		.COLUMN_LIMIT(COLUMN_LIMIT),
		.ARG_CHARS   (ARG_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chr_valid(chr_valid),
		.chr_ready(chr_ready),
		.chr      (chr),
		.q_full   (q_full),
		.push     (q_push),
		.rec      (q_in)
	);

	// line record queue
	ale_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_rec  (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head      (q_head)
	);

	// byte encoder
	ale_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_valid),
		.head      (q_head),
		.pop       (q_pop),
		.code_valid(code_valid),
		.code_ready(code_ready),
		.code      (code)
	);

endmodule

>>> test/ale_tb_pkg.sv
`timescale 1ns / 1ps
package ale_tb_pkg;
	import ale_pkg::*;

	// opcodes in table order
	typedef enum logic [3:0] {
		OPC_NOP, OPC_MOV, OPC_STOR, OPC_LOAD, OPC_INC, OPC_ADD, OPC_ADDIV, OPC_DEC,
		OPC_SUB, OPC_SUBIV, OPC_OR, OPC_AND, OPC_CMP, OPC_JMP, OPC_FLG, OPC_RSTFG
	} opcode_e;

	// mnemonic text of each opcode
	function automatic string op_text(opcode_e op);
		case (op)
			OPC_NOP:   return "NOP";
			OPC_MOV:   return "MOV";
			OPC_STOR:  return "STOR";
			OPC_LOAD:  return "LOAD";
			OPC_INC:   return "INC";
			OPC_ADD:   return "ADD";
			OPC_ADDIV: return "ADDIV";
			OPC_DEC:   return "DEC";
			OPC_SUB:   return "SUB";
			OPC_SUBIV: return "SUBIV";
			OPC_OR:    return "OR";
			OPC_AND:   return "AND";
			OPC_CMP:   return "CMP";
			OPC_JMP:   return "JMP";
			OPC_FLG:   return "FLG";
			default:   return "RSTFG";
		endcase
	endfunction

	function automatic bit is_upper(logic [7:0] c);
		return c >= "A" && c <= "Z";
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// line scanner mirror and queue of code beats still owed by the block
	class asm_line_board;
		int unsigned column;
		bit          in_args;
		logic [7:0]  mnem [5];
		int unsigned mnem_len;
		bit          second_arg;
		bit          scan_done;
		int unsigned arg_len [2];
		logic [15:0] arg_head [2];
		logic [7:0]  arg_num [2];
		bit          digits_open [2];
		bit          line_fault;
		code_item_t  pending_codes [$];
		int          errors;

		function new();
			errors = 0;
			clear_line();
		endfunction

		function void clear_arg(int a);
			arg_len[a]     = 0;
			arg_head[a]    = '0;
			arg_num[a]     = '0;
			digits_open[a] = 1'b1;
		endfunction

		function void clear_line();
			column     = 0;
			in_args    = 1'b0;
			foreach (mnem[k]) mnem[k] = '0;
			mnem_len   = 0;
			second_arg = 1'b0;
			scan_done  = 1'b0;
			clear_arg(0);
			clear_arg(1);
			line_fault = 1'b0;
		endfunction

		// argument text: letters and digits kept, ';' stops, ',' moves on
		function void scan_arg_char(logic [7:0] c);
			int a;
			a = second_arg ? 1 : 0;
			if (scan_done) return;
			if (c == CH_SEMI) begin
				scan_done = 1'b1;
				return;
			end
			if (c == CH_COMMA) begin
				if (second_arg) clear_arg(1);
				second_arg = 1'b1;
				return;
			end
			if (!is_upper(c) && !is_digit(c)) return;
			if (arg_len[a] >= ARG_CHARS_DEF) begin
				line_fault = 1'b1;
				return;
			end
			if (arg_len[a] == 0) begin
				arg_head[a] = {c, 8'h00};
			end else if (arg_len[a] == 1) begin
				arg_head[a][7:0] = c;
			end
			arg_len[a]++;
			if (digits_open[a] && is_digit(c)) begin
				arg_num[a] = 8'(arg_num[a] * 8'd10 + (c - 8'h30));
			end else begin
				digits_open[a] = 1'b0;
			end
		endfunction

		function int find_opcode();
			string name;
			bit    same;
			int    hit;
			hit = -1;
			if (mnem_len == 0 || mnem_len > 5) return -1;
			for (int op = 0; op < 16; op++) begin
				name = op_text(opcode_e'(op));
				if (name.len() == mnem_len) begin
					same = 1'b1;
					for (int k = 0; k < mnem_len; k++) begin
						if (8'(name[k]) != mnem[k]) same = 1'b0;
					end
					if (same && hit < 0) hit = op;
				end
			end
			return hit;
		endfunction

		function logic [1:0] reg_of(int a);
			if (arg_len[a] != 2) return REG_NONE;
			if (arg_head[a] == TXT_AL) return REG_AL;
			if (arg_head[a] == TXT_BL) return REG_BL;
			if (arg_head[a] == TXT_CL) return REG_CL;
			return REG_NONE;
		endfunction

		function void owe_code(logic [7:0] b, logic last, logic bad);
			code_item_t e;
			e.code_byte    = b;
			e.last_of_line = last;
			e.bad_line     = bad;
			pending_codes.push_back(e);
		endfunction

		// bytes owed for the line just closed
		function void encode_line();
			int         op;
			logic [3:0] opc;
			logic [1:0] r0;
			logic [1:0] r1;
			op = find_opcode();
			opc = 4'(op);
			if (op < 0) begin
				owe_code(8'h00, 1'b1, 1'b1);
			end else if (opc == OP_NOP || opc == OP_RSTFG) begin
				owe_code({opc, 4'h0}, 1'b1, 1'b0);
			end else if (line_fault) begin
				owe_code(8'h00, 1'b1, 1'b1);
			end else if (opc == OP_JMP || opc == OP_FLG) begin
				owe_code({opc, 4'h0}, 1'b0, 1'b0);
				owe_code(arg_num[0], 1'b1, 1'b0);
			end else begin
				r0 = reg_of(0);
				r1 = reg_of(1);
				if (r0 != REG_NONE && r1 != REG_NONE) begin
					owe_code({opc, r0, r1}, 1'b1, 1'b0);
				end else begin
					owe_code({opc, r0, r1}, 1'b0, 1'b0);
					owe_code((r1 == REG_NONE) ? arg_num[1] : arg_num[0], 1'b1, 1'b0);
				end
			end
		endfunction

		// accepted character beat
		function void note_char(char_item_t item);
			logic [7:0] c;
			c = item.ch;
			if (column < COLUMN_LIMIT_DEF) begin
				column++;
				if (!in_args && is_upper(c)) begin
					if (mnem_len < 5) mnem[mnem_len] = c;
					if (mnem_len < 6) mnem_len++;
				end else begin
					in_args = 1'b1;
					scan_arg_char(c);
				end
			end
			if (item.line_end) begin
				encode_line();
				clear_line();
			end
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		// accepted code beat against the oldest owed one
		task check_code(code_item_t got);
			code_item_t want;
			if (pending_codes.size() == 0) begin
				report_mismatch($sformatf("code beat %02h with none owed", got.code_byte));
				return;
			end
			want = pending_codes.pop_front();
			if (got.code_byte !== want.code_byte)
				report_mismatch($sformatf("code_byte %02h, wanted %02h",
					got.code_byte, want.code_byte));
			if (got.last_of_line !== want.last_of_line)
				report_mismatch($sformatf("last_of_line %b, wanted %b",
					got.last_of_line, want.last_of_line));
			if (got.bad_line !== want.bad_line)
				report_mismatch($sformatf("bad_line %b, wanted %b",
					got.bad_line, want.bad_line));
		endtask

		function int owed();
			return pending_codes.size();
		endfunction
	endclass

endpackage

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import ale_pkg::*;
	import ale_tb_pkg::*;

	localparam int CHAR_ITEMS   = 1000;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;

	logic       clk;
	logic       arst_n;
	logic       chr_valid;
	logic       chr_ready;
	char_item_t chr;
	logic       code_valid;
	logic       code_ready;
	code_item_t code;

	asm_line_board board;
	bit            gaps_on;
	int            chars_sent;
	int            cycle_count;

	assembly_line_encoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.chr_valid  (chr_valid),
		.chr_ready  (chr_ready),
		.chr        (chr),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// beat monitor: character beats noted before code beats checked
	always @(posedge clk) begin
		cycle_count++;
		if (chr_valid && chr_ready) board.note_char(chr);
		if (code_valid && code_ready) board.check_code(code);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		code_ready <= !(gaps_on && $urandom_range(99) < 11);
	end

	task automatic send_char(logic [7:0] c, logic last);
		while (gaps_on && $urandom_range(99) < 11) begin
			chr_valid <= 1'b0;
			@(negedge clk);
		end
		chr       <= '{ch: c, line_end: last};
		chr_valid <= 1'b1;
		do @(posedge clk); while (!chr_ready);
		chars_sent++;
		// quiet stretch with no idling on either side
		gaps_on = !(chars_sent >= 400 && chars_sent < 600);
		@(negedge clk);
	endtask

	task automatic send_line(byte unsigned q[$]);
		foreach (q[i]) send_char(q[i], i == q.size() - 1);
	endtask

	// sender idles until every owed code beat has come
	task automatic wait_drained();
		chr_valid <= 1'b0;
		while (board.owed() != 0) @(negedge clk);
	endtask

	function automatic void add_text(ref byte unsigned q[$], input string s);
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
	endfunction

	function automatic byte unsigned rand_alnum();
		int r;
		r = $urandom_range(35);
		return (r < 10) ? 8'("0" + r) : 8'("A" + r - 10);
	endfunction

	// printable filler, commas and semicolons among it
	function automatic byte unsigned rand_print();
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic void add_arg(ref byte unsigned q[$]);
		string regs [3];
		string near [4];
		regs = '{"AL", "BL", "CL"};
		near = '{"DL", "ALX", "A", "C1"};
		case ($urandom_range(6))
			0, 1: add_text(q, regs[$urandom_range(2)]);
			2: add_text(q, near[$urandom_range(3)]);
			3: add_text(q, $sformatf("%0d", $urandom_range(255)));
			4: add_text(q, $sformatf("%0d", $urandom()));
			5: repeat ($urandom_range(1, 9)) q.push_back(rand_alnum());
			default: ;
		endcase
		if ($urandom_range(9) == 0) q.push_back(8'("a" + $urandom_range(25)));
	endfunction

	// mostly well-formed source line with random content
	function automatic void make_line(ref byte unsigned q[$]);
		int nargs;
		q.delete();
		case ($urandom_range(19))
			0: ;
			1, 2: repeat ($urandom_range(1, 6)) q.push_back(8'("A" + $urandom_range(25)));
			default: add_text(q, op_text(opcode_e'($urandom_range(15))));
		endcase
		case ($urandom_range(4))
			0: add_text(q, "  ");
			1: add_text(q, "\t");
			2: ;
			default: add_text(q, " ");
		endcase
		nargs = $urandom_range(3);
		for (int i = 0; i < nargs; i++) begin
			if (i > 0) begin
				q.push_back(CH_COMMA);
				if ($urandom_range(2) == 0) q.push_back(" ");
			end
			add_arg(q);
		end
		if ($urandom_range(3) == 0) begin
			add_text(q, " ;");
			repeat ($urandom_range(8)) q.push_back(rand_print());
		end
		if ($urandom_range(7) == 0) q.insert($urandom_range(q.size()), rand_print());
		if (q.size() == 0) q.push_back(" ");
	endfunction

	initial begin
		byte unsigned line_q [$];
		int           lines;
		board       = new();
		arst_n      = 1'b0;
		chr_valid   = 1'b0;
		chr         = '0;
		code_ready  = 1'b0;
		gaps_on     = 1'b1;
		chars_sent  = 0;
		cycle_count = 0;
		lines       = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: register pair after a further comma, over-long argument,
		// empty mnemonic at both ends of the character range
		line_q.delete();
		add_text(line_q, "MOV AL,B,CL");
		send_line(line_q);
		line_q.delete();
		add_text(line_q, "JMP 12345678");
		send_line(line_q);
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		wait_drained();

		// random lines: well-formed, cut short, or raw bytes
		while (chars_sent < CHAR_ITEMS) begin
			case ($urandom_range(9))
				0: begin
					line_q.delete();
					repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(255)));
				end
				1: begin
					make_line(line_q);
					while (line_q.size() > 1 && $urandom_range(1) == 0) void'(line_q.pop_back());
				end
				default: make_line(line_q);
			endcase
			send_line(line_q);
			lines++;
			if (lines == 40) wait_drained();
		end
		chr_valid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.errors == 0 && board.owed() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> assembly_line_encoder.f
src/ale_pkg.sv
src/ale_front.sv
src/ale_queue.sv
src/ale_back.sv
src/assembly_line_encoder.sv
test/ale_tb_pkg.sv
test/tb_top.sv
